[rtl/cskl_pkg.sv]
// ----------------------------------------------------------------------------
// cskl_pkg: shared types and constants of the CAN slave login/keepalive block
// Payload structs, reply job descriptor, frame IDs and login run table.
// ----------------------------------------------------------------------------
`default_nettype none

package cskl_pkg;

    typedef struct packed {
        logic        operation;
        logic [28:0] frame_id;
    } t_in_item;

    typedef struct packed {
        logic [28:0] tx_id;
        logic [3:0]  tx_length;
        logic [63:0] tx_payload;
        logic        run_end;
    } t_out_item;

    typedef enum logic [1:0] {
        JOB_ACK,
        JOB_DISCOVER,
        JOB_PING,
        JOB_LOGIN
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic [7:0]  address;
    } t_job;

    localparam int          QUEUE_DEPTH  = 4;
    localparam logic [15:0] PERIOD_RESET = 16'd1000;
    localparam logic [3:0]  REINIT_RESET = 4'd8;

    localparam logic [28:0] ID_DISCOVER    = 29'h1c00007e;
    localparam logic [28:0] ID_SLAVE_PING  = 29'h0c000380;
    localparam logic [28:0] ID_PONG        = 29'h08000900;
    localparam logic [28:0] ID_MASTER_PING = 29'h0c000380;
    localparam logic [28:0] ID_LOGIN       = 29'h00000380;
    localparam logic [28:0] ID_QUERY       = 29'h1c0000fe;
    localparam logic [28:0] ID_ALIVE       = 29'h1c0380fe;
    localparam logic [28:0] ID_ADDR_MASK   = 29'h00007c00;
    localparam logic [28:0] ID_ALIVE_ACK   = 29'h0c000381;
    localparam logic [63:0] ALIVE_ACK_DATA = 64'h000000010005E65E;

    localparam logic [2:0]  LOGIN_LAST = 3'd6;

    // One frame of a reply job; idx selects the frame within a login run.
    function automatic t_out_item frame_of(t_job job, logic [2:0] idx);
        t_out_item f;
        f = '0;
        case (job.kind)
            JOB_ACK: begin
                f.tx_id      = ID_ALIVE_ACK;
                f.tx_length  = 4'd8;
                f.tx_payload = ALIVE_ACK_DATA;
                f.run_end    = 1'b1;
            end
            JOB_DISCOVER: begin
                f.tx_id   = ID_DISCOVER;
                f.run_end = 1'b1;
            end
            JOB_PING: begin
                f.tx_id     = ID_SLAVE_PING;
                f.tx_length = 4'd4;
                f.run_end   = 1'b1;
            end
            JOB_LOGIN: begin
                case (idx)
                    3'd0: f.tx_id = 29'h1C14807E;
                    3'd1: f.tx_id = 29'h1F99007E;
                    3'd2: f.tx_id = 29'h1D75807E;
                    3'd3: begin
                        f.tx_id      = 29'h1C02007E;
                        f.tx_length  = 4'd8;
                        f.tx_payload = 64'h0005E65E00020003;
                    end
                    3'd4: begin
                        f.tx_id      = 29'h1C02807E;
                        f.tx_length  = 4'd8;
                        f.tx_payload = 64'h000000970200C011;
                    end
                    3'd5: begin
                        f.tx_id      = 29'h1C03007E;
                        f.tx_length  = 4'd8;
                        f.tx_payload = 64'h010102140000C011;
                    end
                    3'd6: begin
                        f.tx_id      = 29'h1C03807E;
                        f.tx_length  = 4'd8;
                        f.tx_payload = 64'h000040110107002A;
                    end
                    default: f.tx_id = '0;
                endcase
                f.tx_id   = f.tx_id | {13'd0, job.address, 8'd0};
                f.run_end = (idx == LOGIN_LAST);
            end
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

[rtl/can_slave_keepalive_login.sv]
// ----------------------------------------------------------------------------
// can_slave_keepalive_login: CAN slave login and keepalive engine
// Tracks the link with a master and builds the reply frames it calls for.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+---------------------------
//   input    | in        | i_in_valid / o_in_ready | t_in_item (tick or frame ID)
//   output   | out       | o_out_valid/i_out_ready | t_out_item (one tx frame)
//   config   | in        | psel/penable/pready     | 32-bit APB register access
//
// Flow: the front takes one input transfer per cycle while the job queue
// has room; state updates at the accepting edge. The back emits one frame
// per cycle from the output register unless the output is held: one frame
// for ack, discover or ping, seven frames for a login run. The sustained
// rate is thus set by the frame generator, at one output frame per cycle.
// Reset: synchronous, active low; clears link state, queue and output valid,
// and loads keepalive_period 1000 and reinit_limit 8.
// Stalls: a held output only backs up the queue; input stalls only when the
// queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module can_slave_keepalive_login #(
    parameter int QUEUE_DEPTH = cskl_pkg::QUEUE_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input transfers
    input  wire logic               i_in_valid,
    input  wire cskl_pkg::t_in_item i_in_data,
    output logic                    o_in_ready,
    // output transfers
    output logic                    o_out_valid,
    output cskl_pkg::t_out_item     o_out_data,
    input  wire logic               i_out_ready,
    // register port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import cskl_pkg::*;

    // register index from the word address
    localparam logic REG_KEEPALIVE_PERIOD = 1'b0;
    localparam logic REG_REINIT_LIMIT     = 1'b1;

    logic [15:0] r_keepalive_period;
    logic [3:0]  r_reinit_limit;

    logic        cfg_write;
    logic        queue_full;
    logic        push;
    t_job        push_job;
    logic        head_valid;
    t_job        head_job;
    logic        pop;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // hold configuration; write at the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keepalive_period <= PERIOD_RESET;
            r_reinit_limit     <= REINIT_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_KEEPALIVE_PERIOD: r_keepalive_period <= pwdata[15:0];
                REG_REINIT_LIMIT:     r_reinit_limit     <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_KEEPALIVE_PERIOD: prdata = {16'd0, r_keepalive_period};
            REG_REINIT_LIMIT:     prdata = {28'd0, r_reinit_limit};
            default:              prdata = '0;
        endcase
    end

    // front: classify the transfer, advance link state, queue a reply job
    cskl_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_data          (i_in_data),
        .o_in_ready         (o_in_ready),
        .i_queue_full       (queue_full),
        .o_push             (push),
        .o_job              (push_job),
        .i_keepalive_period (r_keepalive_period),
        .i_reinit_limit     (r_reinit_limit)
    );

    // decouple intake from frame generation
    cskl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (push_job),
        .o_full       (queue_full),
        .o_head_valid (head_valid),
        .o_head       (head_job),
        .i_pop        (pop)
    );

    // back: expand each job into its frames
    cskl_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head_job),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_ready  (i_out_ready)
    );

endmodule

`default_nettype wire

[rtl/cskl_front.sv]
// ----------------------------------------------------------------------------
// cskl_front: item intake and link state
// Classifies ticks and received IDs, updates link state, emits reply jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module cskl_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire cskl_pkg::t_in_item i_in_data,
    output logic                    o_in_ready,
    input  wire logic               i_queue_full,
    output logic                    o_push,
    output cskl_pkg::t_job          o_job,
    input  wire logic [15:0]        i_keepalive_period,
    input  wire logic [3:0]         i_reinit_limit
);
    import cskl_pkg::*;

    typedef enum logic [1:0] {
        MODE_INIT      = 2'd0,
        MODE_HANDSHAKE = 2'd1,
        MODE_KEEPALIVE = 2'd2
    } t_link_mode;

    t_link_mode  r_mode, n_mode;
    logic        r_seen, n_seen;
    logic [3:0]  r_missed, n_missed;
    logic [7:0]  r_addr, n_addr;
    logic [15:0] r_timer, n_timer;
    logic        n_push;
    t_job        n_job;
    logic        accept;
    logic [15:0] timer_inc;
    logic [3:0]  missed_inc;
    logic [28:0] id;

    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;
    assign id         = i_in_data.frame_id;
    assign timer_inc  = r_timer + 16'd1;
    assign missed_inc = r_missed + 4'd1;

    always_comb begin
        n_mode      = r_mode;
        n_seen      = r_seen;
        n_missed    = r_missed;
        n_addr      = r_addr;
        n_timer     = r_timer;
        n_push      = 1'b0;
        n_job.kind    = JOB_DISCOVER;
        n_job.address = r_addr;
        if (i_in_data.operation) begin
            if (id == ID_PONG) begin
                n_mode   = MODE_KEEPALIVE;
                n_missed = '0;
            end else if (id == ID_MASTER_PING) begin
                n_mode     = MODE_KEEPALIVE;
                n_missed   = '0;
                n_push     = 1'b1;
                n_job.kind = JOB_ACK;
            end else if (id == ID_LOGIN) begin
                n_mode     = MODE_HANDSHAKE;
                n_seen     = 1'b1;
                n_push     = 1'b1;
                n_job.kind = JOB_DISCOVER;
            end else if ((id & ~ID_ADDR_MASK) == ID_QUERY) begin
                // capture ID bits 14..10 as address bits 6..2
                n_addr        = {1'b0, id[14:10], 2'b00};
                n_push        = 1'b1;
                n_job.kind    = JOB_LOGIN;
                n_job.address = {1'b0, id[14:10], 2'b00};
            end else if ((id & ~ID_ADDR_MASK) == ID_ALIVE) begin
                n_seen = 1'b1;
                n_mode = MODE_KEEPALIVE;
            end
        end else begin
            n_timer = timer_inc;
            if (timer_inc >= i_keepalive_period) begin
                n_timer = '0;
                if (r_seen) begin
                    n_seen = 1'b0;
                end else if (r_mode == MODE_KEEPALIVE) begin
                    n_missed = missed_inc;
                    n_push   = 1'b1;
                    if (missed_inc > i_reinit_limit) begin
                        n_mode     = MODE_INIT;
                        n_job.kind = JOB_DISCOVER;
                    end else begin
                        n_job.kind = JOB_PING;
                    end
                end else begin
                    n_push     = 1'b1;
                    n_job.kind = JOB_DISCOVER;
                end
            end
        end
    end

    assign o_push = accept && n_push;
    assign o_job  = n_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_INIT;
            r_seen   <= 1'b0;
            r_missed <= '0;
            r_addr   <= '0;
            r_timer  <= '0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_seen   <= n_seen;
            r_missed <= n_missed;
            r_addr   <= n_addr;
            r_timer  <= n_timer;
        end
    end

endmodule

`default_nettype wire

[rtl/cskl_queue.sv]
// ----------------------------------------------------------------------------
// cskl_queue: reply job queue
// Small register FIFO between intake and frame generation.
// ----------------------------------------------------------------------------
`default_nettype none

module cskl_queue #(
    parameter int DEPTH = cskl_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire cskl_pkg::t_job i_job,
    output logic                o_full,
    output logic                o_head_valid,
    output cskl_pkg::t_job      o_head,
    input  wire logic           i_pop
);
    import cskl_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/cskl_back.sv]
// ----------------------------------------------------------------------------
// cskl_back: reply frame generator
// Expands queued jobs into frames, one per cycle while the output is not held, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cskl_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_head_valid,
    input  wire cskl_pkg::t_job i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    output cskl_pkg::t_out_item o_out_data,
    input  wire logic           i_out_ready
);
    import cskl_pkg::*;

    logic      r_active;
    t_job      r_job;
    logic [2:0] r_idx;
    logic      r_out_valid;
    t_out_item r_out_data;

    logic       src_valid;
    t_job       src_job;
    logic [2:0] src_idx;
    logic       load;
    t_out_item  frame;

    always_comb begin
        src_valid = r_active || i_head_valid;
        src_job   = r_active ? r_job : i_head;
        src_idx   = r_active ? r_idx : 3'd0;
        load      = src_valid && (!r_out_valid || i_out_ready);
        frame     = frame_of(src_job, src_idx);
    end

    assign o_pop       = load && !r_active;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
            r_active    <= !frame.run_end;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data <= frame;
            r_job      <= src_job;
            r_idx      <= src_idx + 3'd1;
        end
    end

endmodule

`default_nettype wire
